// ===== design/bma_pkg.sv =====
// shared types, opcodes and partial-product helpers for the barrett modular alu
// no dependencies
package bma_pkg;

  typedef enum logic [2:0] {
    OP_REDUCE      = 3'd0,
    OP_REDUCE_WIDE = 3'd1,
    OP_ADD         = 3'd2,
    OP_SUB         = 3'd3,
    OP_NEG         = 3'd4,
    OP_MUL         = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    REG_MODULUS    = 3'd0,
    REG_FACTOR     = 3'd1,
    REG_SHIFT      = 3'd2,
    REG_SHORT      = 3'd3,
    REG_RES_52     = 3'd4,
    REG_RES_104    = 3'd5
  } reg_idx_t;

  localparam int LimbBits = 52;

  typedef struct packed {
    logic [61:0] q;
    logic [63:0] m;
    logic [6:0]  k;
    logic [51:0] sf;
    logic [61:0] r52;
    logic [61:0] r104;
  } cfg_t;

  typedef struct packed {
    logic [63:0] ll;
    logic [63:0] lh;
    logic [63:0] hl;
    logic [63:0] hh;
  } pp_t;

  // front end to barrett stage
  typedef struct packed {
    logic         simple;
    logic [63:0]  sres;
    logic         short_p;
    logic [63:0]  lo;
    logic [127:0] p1;
    logic [127:0] p2;
    logic [127:0] ps;
  } fr_t;

  // barrett stage to correction
  typedef struct packed {
    logic        done;
    logic [63:0] dres;
    logic [63:0] rlo;
    pp_t         pq;
  } br_t;

  function automatic pp_t pp_mul(input logic [63:0] a, input logic [63:0] b);
    pp_t r;
    r.ll = a[31:0] * b[31:0];
    r.lh = a[31:0] * b[63:32];
    r.hl = a[63:32] * b[31:0];
    r.hh = a[63:32] * b[63:32];
    return r;
  endfunction

  function automatic logic [127:0] pp_sum(input pp_t p);
    return {64'd0, p.ll} + {32'd0, p.lh, 32'd0} + {32'd0, p.hl, 32'd0} + {p.hh, 64'd0};
  endfunction

  function automatic logic [63:0] pp_lo64(input pp_t p);
    return p.ll + {p.lh[31:0], 32'd0} + {p.hl[31:0], 32'd0};
  endfunction

endpackage

// ===== design/bma_front.sv =====
// front stages: operand product, operand selection, simple ops, limb fold products
// depends on bma_pkg
module bma_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  bma_pkg::cfg_t      cfg,
  input  logic               in_v,
  input  logic [2:0]         op_in,
  input  logic [63:0]        a_in,
  input  logic [63:0]        b_in,
  output logic               out_v,
  output bma_pkg::fr_t       out_d
);

  logic          s1_v, s2_v, s3_v, s4_v;
  logic [2:0]    s1_op, s2_op;
  logic [63:0]   s1_a, s1_b, s2_a, s2_b;
  bma_pkg::pp_t  s1_pp;
  logic [127:0]  s2_p;

  logic          s3_simple, s3_short;
  logic [63:0]   s3_sres, s3_lo;
  bma_pkg::pp_t  s3_pp1, s3_pp2, s3_pps;

  logic [63:0]   hi, lo, sres, t, q64;
  logic          simple;
  logic [51:0]   x1;
  logic [23:0]   x2;

  assign q64 = {2'd0, cfg.q};

  always_comb begin
    hi     = 64'd0;
    lo     = s2_a;
    sres   = 64'd0;
    simple = 1'b1;
    t      = 64'd0;
    unique case (s2_op)
      bma_pkg::OP_REDUCE: begin
        simple = 1'b0;
      end
      bma_pkg::OP_REDUCE_WIDE: begin
        simple = 1'b0;
        hi = s2_a;
        lo = s2_b;
      end
      bma_pkg::OP_MUL: begin
        simple = 1'b0;
        hi = s2_p[127:64];
        lo = s2_p[63:0];
      end
      bma_pkg::OP_ADD: begin
        t = s2_a + s2_b;
        sres = (t >= q64) ? t - q64 : t;
      end
      bma_pkg::OP_SUB: begin
        t = s2_a - s2_b;
        sres = (s2_a < s2_b) ? t + q64 : t;
      end
      bma_pkg::OP_NEG: begin
        sres = (s2_a == 64'd0) ? 64'd0 : q64 - s2_a;
      end
      default: begin
        sres = 64'd0;
      end
    endcase
    x1 = {hi[39:0], lo[63:52]};
    x2 = hi[63:40];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_v;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op <= op_in;
      s1_a  <= a_in;
      s1_b  <= b_in;
      s1_pp <= bma_pkg::pp_mul(a_in, b_in);

      s2_op <= s1_op;
      s2_a  <= s1_a;
      s2_b  <= s1_b;
      s2_p  <= bma_pkg::pp_sum(s1_pp);

      s3_simple <= simple;
      s3_sres   <= sres;
      s3_short  <= (hi == 64'd0) && (lo[63:52] == 12'd0);
      s3_lo     <= lo;
      s3_pp1    <= bma_pkg::pp_mul({12'd0, x1}, {2'd0, cfg.r52});
      s3_pp2    <= bma_pkg::pp_mul({40'd0, x2}, {2'd0, cfg.r104});
      s3_pps    <= bma_pkg::pp_mul(lo, {12'd0, cfg.sf});

      out_d.simple  <= s3_simple;
      out_d.sres    <= s3_sres;
      out_d.short_p <= s3_short;
      out_d.lo      <= s3_lo;
      out_d.p1      <= bma_pkg::pp_sum(s3_pp1);
      out_d.p2      <= bma_pkg::pp_sum(s3_pp2);
      out_d.ps      <= bma_pkg::pp_sum(s3_pps);
    end
  end

  assign out_v = s4_v;

endmodule

// ===== design/bma_barrett.sv =====
// barrett stages: folded sum, short path, quotient estimate, estimate times q
// depends on bma_pkg
module bma_barrett (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  bma_pkg::cfg_t      cfg,
  input  logic               in_v,
  input  bma_pkg::fr_t       in_d,
  output logic               out_v,
  output bma_pkg::br_t       out_d
);

  logic          s5_v, s6_v, s7_v, s8_v, s9_v;

  logic          s5_simple, s5_short;
  logic [63:0]   s5_sres, s5_lo;
  logic [127:0]  s5_r;
  bma_pkg::pp_t  s5_pe;

  logic          s6_simple, s6_short;
  logic [63:0]   s6_sres, s6_rlo, s6_srem;
  bma_pkg::pp_t  s6_ph, s6_pl;

  logic          s7_done;
  logic [63:0]   s7_dres, s7_rlo, s7_t;
  logic [127:0]  s7_acc;

  logic          s8_done;
  logic [63:0]   s8_dres, s8_rlo, s8_est;

  logic [63:0]   q64, s6_sfix;
  logic [127:0]  acc_sum, acc_sh;

  assign q64     = {2'd0, cfg.q};
  assign s6_sfix = (s6_srem >= q64) ? s6_srem - q64 : s6_srem;
  assign acc_sum = s7_acc + {64'd0, s7_t};
  assign acc_sh  = acc_sum >> cfg.k[5:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
      s6_v <= 1'b0;
      s7_v <= 1'b0;
      s8_v <= 1'b0;
      s9_v <= 1'b0;
    end else if (en) begin
      s5_v <= in_v;
      s6_v <= s5_v;
      s7_v <= s6_v;
      s8_v <= s7_v;
      s9_v <= s8_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_simple <= in_d.simple;
      s5_short  <= in_d.short_p;
      s5_sres   <= in_d.sres;
      s5_lo     <= in_d.lo;
      s5_r      <= {76'd0, in_d.lo[bma_pkg::LimbBits-1:0]} + in_d.p1 + in_d.p2;
      s5_pe     <= bma_pkg::pp_mul(in_d.ps[115:52], q64);

      s6_simple <= s5_simple;
      s6_short  <= s5_short;
      s6_sres   <= s5_sres;
      s6_rlo    <= s5_r[63:0];
      s6_srem   <= s5_lo - bma_pkg::pp_lo64(s5_pe);
      s6_ph     <= bma_pkg::pp_mul(s5_r[127:64], cfg.m);
      s6_pl     <= bma_pkg::pp_mul(s5_r[63:0], cfg.m);

      s7_done <= s6_simple | s6_short;
      s7_dres <= s6_simple ? s6_sres : s6_sfix;
      s7_rlo  <= s6_rlo;
      s7_acc  <= bma_pkg::pp_sum(s6_ph);
      s7_t    <= 64'(bma_pkg::pp_sum(s6_pl) >> 64);

      s8_done <= s7_done;
      s8_dres <= s7_dres;
      s8_rlo  <= s7_rlo;
      s8_est  <= acc_sh[63:0];

      out_d.done <= s8_done;
      out_d.dres <= s8_dres;
      out_d.rlo  <= s8_rlo;
      out_d.pq   <= bma_pkg::pp_mul(s8_est, q64);
    end
  end

  assign out_v = s9_v;

endmodule

// ===== design/bma_correct.sv =====
// correction stages: remainder, three capped subtractions, result select
// depends on bma_pkg
module bma_correct (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  bma_pkg::cfg_t      cfg,
  input  logic               in_v,
  input  bma_pkg::br_t       in_d,
  output logic               out_v,
  output logic [61:0]        res
);

  logic          s10_v, s11_v, s12_v;
  logic          s10_done, s11_done;
  logic [63:0]   s10_dres, s11_dres, s10_rem, s11_rem;
  logic [63:0]   q64, c1, c2, c3, fin;

  assign q64 = {2'd0, cfg.q};
  assign c1  = (s10_rem >= q64) ? s10_rem - q64 : s10_rem;
  assign c2  = (c1 >= q64) ? c1 - q64 : c1;
  assign c3  = (s11_rem >= q64) ? s11_rem - q64 : s11_rem;
  assign fin = s11_done ? s11_dres : c3;

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_v <= 1'b0;
      s11_v <= 1'b0;
      s12_v <= 1'b0;
    end else if (en) begin
      s10_v <= in_v;
      s11_v <= s10_v;
      s12_v <= s11_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s10_done <= in_d.done;
      s10_dres <= in_d.dres;
      s10_rem  <= in_d.rlo - bma_pkg::pp_lo64(in_d.pq);

      s11_done <= s10_done;
      s11_dres <= s10_dres;
      s11_rem  <= c2;

      res <= fin[61:0];
    end
  end

  assign out_v = s12_v;

endmodule

// ===== design/barrett_modular_alu.sv =====
// barrett modular alu: request channel, result channel, configuration registers
// usage:
//   configuration words (index, data) load q, m, k, the short factor and the
//   residues of 2^52 and 2^104; the write channel is ready whenever rst is low
//   each request word carries req_type, operand_a, operand_b and yields one
//   residue word on the result channel, in request order
// throughput: one request per cycle unless the result word is held by the receiver;
//   twelve register stages carry valid bits with the data, the 64x64 products are
//   split into 32x32 partials over two stages each
// reset: clears all stage valid bits and loads the register defaults; both
//   ready outputs stay low while rst is high
// stall: when the result word is held by the receiver the whole pipeline
//   freezes and in_ready drops; nothing is lost or repeated
// depends on bma_pkg, bma_front, bma_barrett, bma_correct
module barrett_modular_alu (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [63:0] operand_a,
  input  logic [63:0] operand_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [61:0] residue
);

  bma_pkg::cfg_t cfg;
  bma_pkg::fr_t  fr_d;
  bma_pkg::br_t  br_d;
  logic          fr_v, br_v, en;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en && !rst;
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.q    <= 62'd2;
      cfg.m    <= 64'h8000_0000_0000_0000;
      cfg.k    <= 7'd64;
      cfg.sf   <= 52'h8_0000_0000_0000;
      cfg.r52  <= 62'd0;
      cfg.r104 <= 62'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bma_pkg::REG_MODULUS: cfg.q    <= cfg_data[61:0];
        bma_pkg::REG_FACTOR:  cfg.m    <= cfg_data;
        bma_pkg::REG_SHIFT:   cfg.k    <= cfg_data[6:0];
        bma_pkg::REG_SHORT:   cfg.sf   <= cfg_data[51:0];
        bma_pkg::REG_RES_52:  cfg.r52  <= cfg_data[61:0];
        bma_pkg::REG_RES_104: cfg.r104 <= cfg_data[61:0];
        default: begin
        end
      endcase
    end
  end

  bma_front u_front (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .cfg   (cfg),
    .in_v  (in_valid),
    .op_in (req_type),
    .a_in  (operand_a),
    .b_in  (operand_b),
    .out_v (fr_v),
    .out_d (fr_d)
  );

  bma_barrett u_barrett (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .cfg   (cfg),
    .in_v  (fr_v),
    .in_d  (fr_d),
    .out_v (br_v),
    .out_d (br_d)
  );

  bma_correct u_correct (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .cfg   (cfg),
    .in_v  (br_v),
    .in_d  (br_d),
    .out_v (out_valid),
    .res   (residue)
  );

endmodule

// ===== tb/sv/barrett_modular_alu_tb.sv =====
// self-checking testbench for barrett_modular_alu: directed and random request words
// under random idling on both channels, checked against an in-bench residue predictor
// depends on bma_pkg and the barrett_modular_alu rtl
module barrett_modular_alu_tb;

  typedef struct {
    logic [2:0]  op;
    logic [63:0] a;
    logic [63:0] b;
  } req_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 0;
  logic [63:0] cfg_data = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [2:0]  req_type = 0;
  logic [63:0] operand_a = 0;
  logic [63:0] operand_b = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [61:0] residue;

  barrett_modular_alu dut (.*);

  always #1 clk = ~clk;

  logic [61:0]  mod_q;
  logic [63:0]  fac_m;
  logic [6:0]   sh_k;
  logic [51:0]  sfac;
  logic [61:0]  r52;
  logic [61:0]  r104;

  req_t         pending_reqs[$];
  logic [61:0]  expected_residues[$];
  int           errors = 0;
  int           cycles = 0;
  bit           hold_sender = 0;
  int           in_gap = 0;
  int           out_gap = 0;

  task automatic report(input string msg);
    $display("error: %s", msg);
    errors++;
  endtask

  function automatic logic [63:0] fold(input logic [63:0] x0, input logic [63:0] x1,
                                       input logic [63:0] x2);
    logic [127:0] r;
    logic [127:0] acc;
    logic [127:0] lo_prod;
    logic [63:0]  est;
    logic [63:0]  rem;
    logic [63:0]  q64;
    q64 = {2'b0, mod_q};
    r = {64'd0, x0} + 128'(x1) * 128'({2'b0, r52}) + 128'(x2) * 128'({2'b0, r104});
    lo_prod = 128'(r[63:0]) * 128'(fac_m);
    acc = 128'(r[127:64]) * 128'(fac_m) + {64'd0, lo_prod[127:64]};
    est = 64'(acc >> sh_k[5:0]);
    rem = r[63:0] - est * q64;
    for (int i = 0; i < 3; i++) if (rem >= q64) rem -= q64;
    return rem;
  endfunction

  function automatic logic [63:0] reduce_one(input logic [63:0] x);
    logic [127:0] p;
    logic [63:0]  est;
    logic [63:0]  rem;
    if (x < 64'(1) << 52) begin
      p = 128'(x) * 128'(sfac);
      est = 64'(p >> 52);
      rem = x - est * {2'b0, mod_q};
      if (rem >= {2'b0, mod_q}) rem -= {2'b0, mod_q};
      return rem;
    end
    return fold({12'd0, x[51:0]}, {52'd0, x[63:52]}, 64'd0);
  endfunction

  function automatic logic [63:0] reduce_pair(input logic [63:0] hi, input logic [63:0] lo);
    logic [127:0] w;
    if (hi == 0) return reduce_one(lo);
    w = {hi, lo};
    return fold({12'd0, w[51:0]}, {12'd0, w[103:52]}, {40'd0, w[127:104]});
  endfunction

  function automatic logic [61:0] predict_residue(input req_t r);
    logic [63:0]  q64;
    logic [63:0]  t;
    logic [63:0]  res;
    logic [127:0] p;
    q64 = {2'b0, mod_q};
    case (r.op)
      bma_pkg::OP_REDUCE: res = reduce_one(r.a);
      bma_pkg::OP_REDUCE_WIDE: res = reduce_pair(r.a, r.b);
      bma_pkg::OP_ADD: begin
        t = r.a + r.b;
        res = (t >= q64) ? t - q64 : t;
      end
      bma_pkg::OP_SUB: begin
        t = r.a - r.b;
        res = (t > r.a) ? t + q64 : t;
      end
      bma_pkg::OP_NEG: res = (r.a == 0) ? 64'd0 : q64 - r.a;
      bma_pkg::OP_MUL: begin
        p = 128'(r.a) * 128'(r.b);
        res = reduce_pair(p[127:64], p[63:0]);
      end
      default: res = 0;
    endcase
    return res[61:0];
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      in_valid <= 0;
    end else if (in_valid && !in_ready) begin
    end else begin
      if (in_valid) expected_residues.push_back(predict_residue('{req_type, operand_a, operand_b}));
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 0;
      end else if (pending_reqs.size() > 0 && !hold_sender) begin
        req_t r;
        r = pending_reqs.pop_front();
        in_valid <= 1;
        req_type <= r.op;
        operand_a <= r.a;
        operand_b <= r.b;
        in_gap <= ($urandom_range(0, 3) == 0) ?
                  (($urandom_range(0, 15) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3)) : 0;
      end else begin
        in_valid <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_residues.size() == 0) begin
          report($sformatf("unexpected residue word %h", residue));
        end else begin
          logic [61:0] e;
          e = expected_residues.pop_front();
          if (residue !== e) report($sformatf("residue %h, expected %h", residue, e));
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
        if ($urandom_range(0, 4) == 0)
          out_gap <= ($urandom_range(0, 15) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 400000) begin
      $display("barrett_modular_alu: mismatch");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return '1;
      2: return {32'd0, $urandom()};
      3: return {$urandom(), $urandom()} >> $urandom_range(0, 63);
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic logic [63:0] rand_below(input logic [61:0] q);
    return {$urandom(), $urandom()} % {2'b0, q};
  endfunction

  task automatic write_reg(input bma_pkg::reg_idx_t idx, input logic [63:0] v);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      bma_pkg::REG_MODULUS: mod_q = v[61:0];
      bma_pkg::REG_FACTOR: fac_m = v;
      bma_pkg::REG_SHIFT: sh_k = v[6:0];
      bma_pkg::REG_SHORT: sfac = v[51:0];
      bma_pkg::REG_RES_52: r52 = v[61:0];
      default: r104 = v[61:0];
    endcase
  endtask

  // derive consistent constants for q and load them
  task automatic load_modulus(input logic [61:0] q);
    logic [6:0]   k;
    logic [191:0] m;
    logic [127:0] r;
    k = 7'(64 + $clog2(64'(q) + 64'd1));
    if (k > 127) k = 127;
    while (((192'(1) << k) / q) >= (192'(1) << 64)) k--;
    m = (192'(1) << k) / q;
    write_reg(bma_pkg::REG_MODULUS, 64'(q));
    write_reg(bma_pkg::REG_FACTOR, m[63:0]);
    write_reg(bma_pkg::REG_SHIFT, 64'(k));
    write_reg(bma_pkg::REG_SHORT,
              (k >= 52) ? 64'(m[63:0] >> (k - 52)) & ((64'(1) << 52) - 1) : 64'd0);
    r = (128'(1) << 52) % q;
    write_reg(bma_pkg::REG_RES_52, r[63:0]);
    r = (128'(1) << 104) % q;
    write_reg(bma_pkg::REG_RES_104, r[63:0]);
  endtask

  task automatic drain();
    wait (pending_reqs.size() == 0 && !in_valid && in_gap == 0);
    @(posedge clk);
    wait (expected_residues.size() == 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic random_phase(input int n, input logic [61:0] q);
    req_t r;
    for (int i = 0; i < n; i++) begin
      r.op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      if ($urandom_range(0, 9) < 7 &&
          (r.op == bma_pkg::OP_ADD || r.op == bma_pkg::OP_SUB || r.op == bma_pkg::OP_NEG)) begin
        r.a = rand_below(q);
        r.b = rand_below(q);
      end else begin
        r.a = rand64();
        r.b = rand64();
      end
      pending_reqs.push_back(r);
    end
  endtask

  logic [61:0] qs[6];

  initial begin
    req_t r;
    qs = '{62'd2, 62'd3, 62'h3fff_ffff_ffff_ffff, 62'd12289, 62'h0fff_ffff_0000_0001, 62'h1};
    repeat (6) @(posedge clk);
    rst <= 0;
    mod_q = 2;
    fac_m = 64'h8000_0000_0000_0000;
    sh_k = 64;
    sfac = 52'h8_0000_0000_0000;
    r52 = 0;
    r104 = 0;
    @(posedge clk);
    // reset constants, directed corners on every opcode
    for (int op = 0; op < 8; op++) begin
      r.op = op[2:0];
      r.a = 0; r.b = 0; pending_reqs.push_back(r);
      r.a = '1; r.b = '1; pending_reqs.push_back(r);
      r.a = 1; r.b = (64'(1) << 52) - 1; pending_reqs.push_back(r);
    end
    drain();
    load_modulus(62'h3fff_ffff_ffff_ffff);
    pending_reqs.push_back('{bma_pkg::OP_REDUCE, (64'(1) << 52) - 1, 64'd0});
    pending_reqs.push_back('{bma_pkg::OP_REDUCE, 64'(1) << 52, 64'd0});
    pending_reqs.push_back('{bma_pkg::OP_REDUCE_WIDE, 64'd0, '1});
    pending_reqs.push_back('{bma_pkg::OP_MUL, '1, '1});
    pending_reqs.push_back('{bma_pkg::OP_SUB, 64'd0, 64'd1});
    pending_reqs.push_back('{bma_pkg::OP_NEG, 64'd5, 64'd0});
    pending_reqs.push_back('{bma_pkg::OP_ADD, 64'h3fff_ffff_ffff_fffe, 64'h3fff_ffff_ffff_fffe});
    random_phase(150, 62'h3fff_ffff_ffff_ffff);
    // stop the sender until the pipeline has emptied
    wait (pending_reqs.size() < 80);
    hold_sender = 1;
    wait (expected_residues.size() == 0 && !in_valid);
    repeat (20) @(posedge clk);
    hold_sender = 0;
    drain();
    for (int s = 0; s < 5; s++) begin
      logic [61:0] q;
      q = (s < 4) ? qs[s] : (62'({$urandom(), $urandom()}) | 62'd2);
      if (q < 2) q = 2;
      load_modulus(q);
      random_phase(180, q);
      drain();
    end
    // inconsistent constants and a shift below sixty-four
    write_reg(bma_pkg::REG_SHIFT, 64'd10);
    write_reg(bma_pkg::REG_FACTOR, '1);
    write_reg(bma_pkg::REG_SHORT, (64'(1) << 52) - 1);
    write_reg(bma_pkg::REG_RES_52, '1);
    write_reg(bma_pkg::REG_RES_104, 64'h3fff_ffff_ffff_fffe);
    random_phase(200, mod_q);
    drain();
    if (errors == 0) begin
      $display("barrett_modular_alu: match");
    end else begin
      $display("barrett_modular_alu: mismatch");
    end
    $finish;
  end
endmodule

// ===== files.f =====
design/bma_pkg.sv
design/bma_front.sv
design/bma_barrett.sv
design/bma_correct.sv
design/barrett_modular_alu.sv
tb/sv/barrett_modular_alu_tb.sv
